### design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Types and constants shared by the partition fit allocator modules.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // partition register file and field widths
    localparam int MAX_PARTS  = 8;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int SIZE_W     = 16;
    localparam int PID_W      = 16;

    // request actions
    localparam logic [1:0] ACT_FIRST   = 2'd0;
    localparam logic [1:0] ACT_BEST    = 2'd1;
    localparam logic [1:0] ACT_WORST   = 2'd2;
    localparam logic [1:0] ACT_RELEASE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOOWNER = 2'd2;

    // request transaction payload
    typedef struct packed {
        logic [1:0]        action;
        logic [PID_W-1:0]  process_id;
        logic [SIZE_W-1:0] request_size;
    } req_t;

    // result transaction payload
    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] block_index;
    } rsp_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;
        logic step;
        logic commit;
    } pfa_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic last;
    } pfa_stat_t;

endpackage

### design/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer: accepts a request, steps the partition scan, then commits the
// outcome into the result register once it is free.
// ----------------------------------------------------------------------------
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output pfa_cmd_t  cmd,
    input  pfa_stat_t stat
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // result slot is free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || !out_stall;

    // command decode
    always_comb
    begin
        cmd.start  = (state_reg == S_IDLE) && in_valid;
        cmd.step   = (state_reg == S_SCAN);
        cmd.commit = (state_reg == S_COMMIT) && slot_free;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.last)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        priority if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/pfa_datapath.sv
// ----------------------------------------------------------------------------
// pfa_datapath
// Partition sizes, usage and owners; one partition examined per scan step,
// with the running choice held in registers until commit.
// ----------------------------------------------------------------------------
module pfa_datapath
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  req_t                 in_data,
    output rsp_t                 out_data,
    input  pfa_cmd_t             cmd,
    output pfa_stat_t            stat
);

    logic [SIZE_W-1:0] size_reg [MAX_PARTS];
    logic [MAX_PARTS-1:0] in_use_reg, in_use_next;
    logic [PID_W-1:0]  owner_reg [MAX_PARTS];

    req_t              req_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [SIZE_W-1:0] best_slack_reg;
    rsp_t              rsp_reg, rsp_next;

    logic [SIZE_W-1:0] cap;
    logic [SIZE_W-1:0] slack;
    logic              fits;
    logic              take;

    // configuration writes, indexes beyond the partition set are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PARTS; i++)
                size_reg[i] <= '0;
        end
        else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(MAX_PARTS)))
        begin
            size_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
        end
    end

    // examine the partition under the scan index
    assign cap   = size_reg[scan_idx_reg];
    assign fits  = !in_use_reg[scan_idx_reg] && (cap >= req_reg.request_size);
    assign slack = cap - req_reg.request_size;

    always_comb
    begin
        unique case (req_reg.action)
            ACT_FIRST:   take = fits && !found_reg;
            ACT_BEST:    take = fits && (!found_reg || (slack < best_slack_reg));
            ACT_WORST:   take = fits && (!found_reg || (slack > best_slack_reg));
            ACT_RELEASE: take = in_use_reg[scan_idx_reg] && !found_reg &&
                                (owner_reg[scan_idx_reg] == req_reg.process_id);
            default:     take = 1'b0;
        endcase
    end

    assign stat.last = (scan_idx_reg == IDX_W'(NUM_BLOCKS - 1));

    // request capture and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg      <= in_data;
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            pick_reg     <= '0;
        end
        else if (cmd.step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (take)
            begin
                found_reg      <= 1'b1;
                pick_reg       <= scan_idx_reg;
                best_slack_reg <= slack;
            end
        end
    end

    // usage update on commit
    always_comb
    begin
        in_use_next = in_use_reg;
        if (cmd.commit && found_reg)
            in_use_next[pick_reg] = (req_reg.action != ACT_RELEASE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_use_reg <= '0;
        else
            in_use_reg <= in_use_next;
    end

    // owner record on a successful allocation
    always_ff @(posedge clk)
    begin
        if (cmd.commit && found_reg && (req_reg.action != ACT_RELEASE))
            owner_reg[pick_reg] <= req_reg.process_id;
    end

    // result register
    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.commit)
        begin
            if (found_reg)
            begin
                rsp_next.status      = ST_DONE;
                rsp_next.block_index = pick_reg;
            end
            else
            begin
                rsp_next.status      = (req_reg.action == ACT_RELEASE) ? ST_NOOWNER
                                                                       : ST_NOFIT;
                rsp_next.block_index = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign out_data = rsp_reg;

endmodule

### design/partition_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator_core
// Fixed partition allocator with first, best and worst fit placement and
// release by owner.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   req_t  (action, process_id, size)
//   out      from block out_valid / out_stall rsp_t  (status, block_index)
//   cfg      to block   cfg_wr_en             cfg_index, cfg_data
//
// Each request is captured, then the scan examines one partition per step, and
// the outcome of the scan is then committed to the output register.
// Reset clears every partition to free and every size register to zero.
// A request is taken while an earlier result still waits in the output
// register; the commit waits only if that register is still held by out_stall.
// ----------------------------------------------------------------------------
module partition_fit_allocator_core
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rsp_t                 out_data
);

    pfa_cmd_t  cmd;
    pfa_stat_t stat;

    // sequencer
    pfa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // partition state and scan datapath
    pfa_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
